### hdl/ile_pkg.sv
// Package for the indexed list engine: sizes, operation and status codes,
// the command and response item types, the RAM request type and the state type.
// Depends on nothing; ile_ctrl, the top level and the testbench import it.
package ile_pkg;

  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COUNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 16;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_GET      = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [POS_W-1:0]   position;
    logic signed [VALUE_W-1:0] item_value;
  } ile_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count_after;
  } ile_rsp_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
  } ile_ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_FILL,
    ST_RESULT
  } ile_state_t;

endpackage

### hdl/ile_ram.sv
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. Depends on nothing.
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/ile_ctrl.sv
// Sequencer of the indexed list engine: decodes a command, keeps the element
// count and walks the element RAM to shift entries up or down.
// Depends on ile_pkg.
module ile_ctrl
  import ile_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ile_cmd_t           cmd,
  input  logic [VALUE_W-1:0] rd_data,
  output ile_ram_req_t       ram_req,
  output logic               res_valid,
  output ile_rsp_t           res,
  input  logic               res_taken
);

  ile_state_t          state;
  ile_state_t          state_next;
  logic [COUNT_W-1:0]  count;
  logic [ADDR_W-1:0]   ptr;
  logic [ADDR_W-1:0]   stop;
  logic [VALUE_W-1:0]  value;

  // Decode of the command on the input.
  logic                neg;
  logic [CMP_W-1:0]    mag;
  logic [CMP_W-1:0]    cnt_ext;
  logic                pos_lt;
  logic                pos_le;
  logic                full;
  logic [COUNT_W-1:0]  cnt_m1_full;
  logic [ADDR_W-1:0]   cnt_m1;
  logic [ADDR_W-1:0]   cnt_addr;
  logic [ADDR_W-1:0]   pos_addr;
  logic [ADDR_W-1:0]   pos_p1;
  logic                ins_req;
  logic [ADDR_W-1:0]   ins_where;
  logic [STATUS_W-1:0] d_status;
  logic [VALUE_W-1:0]  d_rv;
  logic [COUNT_W-1:0]  d_count;
  ile_state_t          d_next;
  logic                d_wr;
  logic                d_rd;
  logic [ADDR_W-1:0]   d_rd_addr;
  logic [ADDR_W-1:0]   d_ptr;
  logic [ADDR_W-1:0]   d_stop;
  logic                accept;

  assign accept      = cmd_valid && cmd_ready;
  assign neg         = cmd.position[POS_W-1];
  assign mag         = CMP_W'({1'b0, cmd.position[POS_W-2:0]});
  assign cnt_ext     = CMP_W'(count);
  assign pos_lt      = !neg && (mag < cnt_ext);
  assign pos_le      = !neg && (mag <= cnt_ext);
  assign full        = (count == COUNT_W'(DEPTH));
  assign cnt_m1_full = count - COUNT_W'(1);
  assign cnt_m1      = cnt_m1_full[ADDR_W-1:0];
  assign cnt_addr    = count[ADDR_W-1:0];
  assign pos_addr    = mag[ADDR_W-1:0];
  assign pos_p1      = pos_addr + ADDR_W'(1);

  always_comb begin
    ins_req   = 1'b0;
    ins_where = '0;
    d_status  = STATUS_DONE;
    d_rv      = '0;
    d_count   = count;
    d_next    = ST_RESULT;
    d_wr      = 1'b0;
    d_rd      = 1'b0;
    d_rd_addr = pos_addr;
    d_ptr     = cnt_m1;
    d_stop    = cnt_m1;
    case (cmd.operation)
      OP_GET: begin
        if (pos_lt) begin
          d_rd   = 1'b1;
          d_next = ST_GET;
        end else begin
          d_status = STATUS_INVALID;
          d_rv     = '1;
        end
      end
      OP_INS_HEAD: begin
        ins_req = 1'b1;
      end
      OP_APPEND: begin
        ins_req   = 1'b1;
        ins_where = cnt_addr;
      end
      OP_INS_AT: begin
        if (neg) begin
          ins_req = 1'b1;
        end else if (!pos_le) begin
          d_status = STATUS_INVALID;
        end else begin
          ins_req   = 1'b1;
          ins_where = pos_addr;
        end
      end
      OP_DELETE: begin
        if (pos_lt) begin
          d_count = cnt_m1_full;
          if (pos_addr != cnt_m1) begin
            d_rd      = 1'b1;
            d_rd_addr = pos_p1;
            d_ptr     = pos_p1;
            d_next    = ST_SHIFT_DN;
          end
        end else begin
          d_status = STATUS_INVALID;
        end
      end
      default: begin
        d_status = STATUS_INVALID;
      end
    endcase
    if (ins_req) begin
      if (full) begin
        d_status = STATUS_FULL;
      end else begin
        d_count = count + COUNT_W'(1);
        d_stop  = ins_where;
        if (ins_where == cnt_addr) begin
          d_wr = 1'b1;
        end else begin
          d_rd      = 1'b1;
          d_rd_addr = cnt_m1;
          d_next    = ST_SHIFT_UP;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = d_next;
        end
      end
      ST_GET: begin
        state_next = ST_RESULT;
      end
      ST_SHIFT_UP: begin
        if (ptr == stop) begin
          state_next = ST_FILL;
        end
      end
      ST_SHIFT_DN: begin
        if (ptr == stop) begin
          state_next = ST_RESULT;
        end
      end
      ST_FILL: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_taken) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The read and write of one cycle always touch different entries, and a
  // command starts only after the previous one has written everything, so
  // no forwarding is needed around the RAM.
  always_comb begin
    cmd_ready       = 1'b0;
    res_valid       = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = stop;
    ram_req.wr_data = value;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = d_rd_addr;
    case (state)
      ST_IDLE: begin
        cmd_ready       = 1'b1;
        ram_req.wr_en   = cmd_valid && d_wr;
        ram_req.wr_addr = cnt_addr;
        ram_req.wr_data = cmd.item_value;
        ram_req.rd_en   = cmd_valid && d_rd;
      end
      ST_SHIFT_UP: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ptr + ADDR_W'(1);
        ram_req.wr_data = rd_data;
        ram_req.rd_en   = (ptr != stop);
        ram_req.rd_addr = ptr - ADDR_W'(1);
      end
      ST_SHIFT_DN: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ptr - ADDR_W'(1);
        ram_req.wr_data = rd_data;
        ram_req.rd_en   = (ptr != stop);
        ram_req.rd_addr = ptr + ADDR_W'(1);
      end
      ST_FILL: begin
        ram_req.wr_en = 1'b1;
      end
      ST_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= d_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ptr             <= d_ptr;
          stop            <= d_stop;
          value           <= cmd.item_value;
          res.read_value  <= d_rv;
          res.status      <= d_status;
          res.count_after <= d_count;
        end
      end
      ST_GET: begin
        res.read_value <= rd_data;
      end
      ST_SHIFT_UP: begin
        if (ptr != stop) begin
          ptr <= ptr - ADDR_W'(1);
        end
      end
      ST_SHIFT_DN: begin
        if (ptr != stop) begin
          ptr <= ptr + ADDR_W'(1);
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("element count beyond store depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) || count == $past(count) + COUNT_W'(1) ||
                count == $past(count) - COUNT_W'(1)))
    else $error("element count moved by more than one");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && ram_req.wr_en) |-> (COUNT_W'(ram_req.wr_addr) < count))
    else $error("shift write outside the held elements");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
    else $error("read and write of the same entry in one cycle");
`endif

endmodule

### hdl/indexed_list_engine_top.sv
// Top level of the indexed list engine: command and response channels,
// the element RAM, the sequencer and the response register.
// Depends on ile_pkg, ile_ram and ile_ctrl.
//
// Usage. A command item (operation, position, item_value) is taken on the
// cmd channel and exactly one response item (read_value, status,
// count_after) comes back on the rsp channel, in command order. The list is
// held in one 1024-entry element RAM; the element count lives in a register.
// One command is worked on at a time; cmd_ready is high while the sequencer
// is idle.
// Append, any refused command and a delete of the last element go straight
// to the result; a get first reads its entry, an insert before a position
// shifts the later entries up and then writes the new one, and a delete
// shifts the later entries down. The time a command takes is set by the
// single RAM port pair: each shifted entry costs one read and one write,
// one entry per cycle. The next command can be taken at the earliest in
// the cycle after the result is handed over, so commands never overlap.
// The response sits in an output register; while the receiver stalls it is
// held there and the sequencer still finishes the next command, then waits
// for that register to empty before it takes another.
// Reset empties the list (count zero) and clears both valid flags; the RAM
// itself is not cleared, as only entries below the count are ever read.
module indexed_list_engine_top
  import ile_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  ile_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ile_rsp_t rsp
);

  ile_ram_req_t       ram_req;
  logic [VALUE_W-1:0] rd_data;
  logic               res_valid;
  ile_rsp_t           res;
  logic               res_taken;

  ile_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // The sequencer hands over its result whenever the response register is
  // empty or being emptied in the same cycle.
  assign res_taken = res_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_taken) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      rsp <= res;
    end
  end

endmodule

### verif/indexed_list_engine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_engine_top: it drives command items, predicts
// each response from its own copy of the list and compares every field.
// Depends on ile_pkg and the indexed_list_engine_top RTL.
module indexed_list_engine_top_tb;
  import ile_pkg::*;

  // Operation codes that the block does not define. It must refuse them.
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN = -(2 ** (POS_W - 1));
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // Fewer than 2000 commands are sent, each one bounded by the longest shift
  // and the waits of the sender and the receiver, so this limit is several
  // times what any correct run can take.
  localparam int LIMIT_CYCLES = 8_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  ile_cmd_t cmd = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  ile_rsp_t rsp;

  // Commands waiting to be sent, and the responses predicted for the commands
  // that the block has already taken.
  ile_cmd_t pending_cmds[$];
  ile_rsp_t awaited_rsps[$];

  // The list as the block should hold it.
  logic signed [VALUE_W-1:0] list_cells [DEPTH];
  int list_len = 0;

  int  mismatches = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  bit  sender_steady = 1'b0;
  bit  receiver_steady = 1'b0;

  indexed_list_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Puts a value in at a given place, moving the later cells up by one. A full
  // list refuses before the place is looked at.
  function automatic logic [STATUS_W-1:0] insert_cell(int where,
                                                      logic signed [VALUE_W-1:0] v);
    if (list_len >= DEPTH) begin
      return STATUS_FULL;
    end
    for (int k = list_len; k > where; k--) begin
      list_cells[k] = list_cells[k - 1];
    end
    list_cells[where] = v;
    list_len++;
    return STATUS_DONE;
  endfunction

  // Carries out one command on the list and gives the response it must cause.
  function automatic void apply_list_command(input ile_cmd_t c, output ile_rsp_t r);
    logic neg;
    int   pos;
    neg = c.position[POS_W-1];
    pos = int'(c.position[POS_W-2:0]);
    r.read_value = '0;
    r.status     = STATUS_DONE;
    case (c.operation)
      OP_GET: begin
        if (!neg && pos < list_len) begin
          r.read_value = list_cells[pos];
        end else begin
          r.read_value = -1;
          r.status     = STATUS_INVALID;
        end
      end
      OP_INS_HEAD: begin
        r.status = insert_cell(0, c.item_value);
      end
      OP_APPEND: begin
        r.status = insert_cell(list_len, c.item_value);
      end
      OP_INS_AT: begin
        // A place beyond the end is refused before fullness is considered.
        if (neg) begin
          r.status = insert_cell(0, c.item_value);
        end else if (pos > list_len) begin
          r.status = STATUS_INVALID;
        end else begin
          r.status = insert_cell(pos, c.item_value);
        end
      end
      OP_DELETE: begin
        if (!neg && pos < list_len) begin
          for (int k = pos; k + 1 < list_len; k++) begin
            list_cells[k] = list_cells[k + 1];
          end
          list_len--;
        end else begin
          r.status = STATUS_INVALID;
        end
      end
      default: begin
        r.status = STATUS_INVALID;
      end
    endcase
    r.count_after = COUNT_W'(list_len);
  endfunction

  function automatic ile_cmd_t build_command(logic [OP_W-1:0] op, int pos,
                                             logic [VALUE_W-1:0] v);
    ile_cmd_t c;
    c.operation  = op;
    c.position   = POS_W'(pos);
    c.item_value = v;
    return c;
  endfunction

  // A random command that steers the list length towards the target: growing
  // commands are favoured below it and deletes above it. Most positions are
  // in range; the rest are negative, just past the end or anywhere at all.
  function automatic ile_cmd_t random_command(int target);
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] v;
    int                 pick;
    int                 pos;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    end else if (pick < 30) begin
      op = OP_GET;
    end else if ($urandom_range(0, 99) < (list_len < target ? 70 : 30)) begin
      case ($urandom_range(0, 3))
        0:       op = OP_INS_HEAD;
        1:       op = OP_APPEND;
        default: op = OP_INS_AT;
      endcase
    end else begin
      op = OP_DELETE;
    end
    case ($urandom_range(0, 15))
      0:       v = VALUE_MAX;
      1:       v = VALUE_MIN;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    case ($urandom_range(0, 19))
      0:       pos = -int'($urandom_range(1, 2 ** (POS_W - 1)));
      1:       pos = int'($urandom_range(0, 2 ** POS_W - 1));
      2:       pos = list_len;
      3:       pos = list_len + 1;
      4:       pos = POS_MAX;
      5:       pos = -1;
      6:       pos = $urandom_range(0, list_len);
      default: pos = list_len > 0 ? $urandom_range(0, list_len - 1) : 0;
    endcase
    return build_command(op, pos, v);
  endfunction

  // Returns once every queued command has been taken and answered.
  task automatic wait_until_idle();
    @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || awaited_rsps.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Command driver. The prediction is made on the edge at which the block
  // takes the item, so the list copy follows the order the block sees.
  always @(posedge clk) begin : cmd_driver
    ile_rsp_t next_rsp;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        apply_list_command(cmd, next_rsp);
        awaited_rsps.push_back(next_rsp);
      end
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd       <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) begin
            sender_steady = !sender_steady;
          end
          send_gap = sender_steady ? 0 : $urandom_range(0, 3);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver back-pressure.
  always @(posedge clk) begin : rsp_monitor
    ile_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsps.size() == 0) begin
          $error("response with no command outstanding: read_value %0d status %0d count %0d",
                 rsp.read_value, rsp.status, rsp.count_after);
          mismatches++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
            mismatches++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.count_after !== want.count_after) begin
            $error("count_after: expected %0d, got %0d", want.count_after, rsp.count_after);
            mismatches++;
          end
        end
        if ($urandom_range(0, 49) == 0) begin
          receiver_steady = !receiver_steady;
        end
        hold_left = receiver_steady ? 0 : $urandom_range(0, 3);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rsp_ready <= (hold_left == 0);
    end
  end

  initial begin : stimulus
    int seg_target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: an empty list, the undefined operations, every way of
    // inserting, gets and deletes at the ends and out of range.
    pending_cmds.push_back(build_command(OP_GET, 0, 0));
    pending_cmds.push_back(build_command(OP_DELETE, 0, 0));
    pending_cmds.push_back(build_command(OP_INS_AT, 1, 7));
    pending_cmds.push_back(build_command(OP_UNDEF_LO, 0, 11));
    pending_cmds.push_back(build_command(OP_W'(OP_UNDEF_LO + 1), -1, VALUE_MIN));
    pending_cmds.push_back(build_command(OP_UNDEF_HI, POS_MAX, VALUE_MAX));
    pending_cmds.push_back(build_command(OP_APPEND, 0, VALUE_MAX));
    pending_cmds.push_back(build_command(OP_INS_HEAD, 0, VALUE_MIN));
    pending_cmds.push_back(build_command(OP_INS_AT, -1, 0));
    pending_cmds.push_back(build_command(OP_INS_AT, 3, -1));
    pending_cmds.push_back(build_command(OP_INS_AT, 1, 12345));
    pending_cmds.push_back(build_command(OP_INS_AT, POS_MIN, 1));
    pending_cmds.push_back(build_command(OP_GET, 0, 0));
    pending_cmds.push_back(build_command(OP_GET, 5, 0));
    pending_cmds.push_back(build_command(OP_GET, 6, 0));
    pending_cmds.push_back(build_command(OP_GET, -1, 0));
    pending_cmds.push_back(build_command(OP_GET, POS_MAX, 0));
    pending_cmds.push_back(build_command(OP_GET, POS_MIN, 0));
    pending_cmds.push_back(build_command(OP_DELETE, POS_MAX, 0));
    pending_cmds.push_back(build_command(OP_DELETE, -1, 0));
    pending_cmds.push_back(build_command(OP_DELETE, 2, 0));
    pending_cmds.push_back(build_command(OP_DELETE, 4, 0));
    pending_cmds.push_back(build_command(OP_DELETE, 0, 0));
    pending_cmds.push_back(build_command(OP_INS_AT, POS_MAX, 3));

    // Hold back until the block has answered everything.
    wait_until_idle();

    // Random commands on short lists. The queue is kept short so that the
    // positions drawn track the current length closely.
    for (int seg = 0; seg < 2; seg++) begin
      seg_target = $urandom_range(2, 64);
      for (int i = 0; i < 50; i++) begin
        while (pending_cmds.size() >= 2) begin
          @(negedge clk);
        end
        pending_cmds.push_back(random_command(seg_target));
      end
    end
    wait_until_idle();

    // Fill the list to capacity with appends, which are quick.
    repeat (DEPTH - list_len) begin
      pending_cmds.push_back(build_command(OP_APPEND, 0, $urandom));
    end
    wait_until_idle();

    // A full list: every insert is refused, as invalid if its place is beyond
    // the end and as full otherwise, then the longest shifts in both directions.
    pending_cmds.push_back(build_command(OP_INS_HEAD, 0, 1));
    pending_cmds.push_back(build_command(OP_APPEND, 0, 2));
    pending_cmds.push_back(build_command(OP_INS_AT, 5, 3));
    pending_cmds.push_back(build_command(OP_INS_AT, -1, 4));
    pending_cmds.push_back(build_command(OP_INS_AT, DEPTH, 5));
    pending_cmds.push_back(build_command(OP_INS_AT, DEPTH + 1, 6));
    pending_cmds.push_back(build_command(OP_GET, DEPTH - 1, 0));
    pending_cmds.push_back(build_command(OP_GET, DEPTH, 0));
    pending_cmds.push_back(build_command(OP_GET, 0, 0));
    pending_cmds.push_back(build_command(OP_DELETE, DEPTH - 1, 0));
    pending_cmds.push_back(build_command(OP_INS_HEAD, 0, VALUE_MIN));
    pending_cmds.push_back(build_command(OP_GET, 0, 0));
    pending_cmds.push_back(build_command(OP_GET, DEPTH - 1, 0));
    pending_cmds.push_back(build_command(OP_DELETE, 0, 0));
    pending_cmds.push_back(build_command(OP_INS_AT, DEPTH - 1, VALUE_MAX));
    pending_cmds.push_back(build_command(OP_DELETE, DEPTH, 0));
    pending_cmds.push_back(build_command(OP_DELETE, 512, 0));
    pending_cmds.push_back(build_command(OP_INS_AT, 300, -1));

    // Random commands that keep the list at or close to capacity.
    for (int i = 0; i < 40; i++) begin
      while (pending_cmds.size() >= 2) begin
        @(negedge clk);
      end
      pending_cmds.push_back(random_command(DEPTH));
    end
    wait_until_idle();

    // Leave room for any response that should not come at all.
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("indexed_list_engine_top: match");
    end else begin
      $display("indexed_list_engine_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("indexed_list_engine_top: mismatch");
    $finish;
  end

endmodule

### indexed_list_engine_top.f
hdl/ile_pkg.sv
hdl/ile_ram.sv
hdl/ile_ctrl.sv
hdl/indexed_list_engine_top.sv
verif/indexed_list_engine_top_tb.sv
